// ----- hdl/uanorm_pkg.sv -----
// Shared types and constants for the UTF-8 normalizing word tokenizer.
// Used by uanorm_step, the top level and its checker; depends on nothing.
`default_nettype none

package uanorm_pkg;

    typedef enum logic [1:0] {
        KIND_BYTE      = 2'd0,
        KIND_TOKEN_END = 2'd1,
        KIND_DONE      = 2'd2,
        KIND_ERROR     = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ERR_UTF8      = 2'd0,
        ERR_TOKENS    = 2'd1,
        ERR_WORKSPACE = 2'd2
    } t_err;

    localparam logic REG_TOKEN_LIMIT     = 1'b0;
    localparam logic REG_WORKSPACE_LIMIT = 1'b1;

    localparam logic [20:0] CP_DIAC_A_LO   = 21'h00064B;
    localparam logic [20:0] CP_DIAC_A_HI   = 21'h00065F;
    localparam logic [20:0] CP_DIAC_B_LO   = 21'h0006D6;
    localparam logic [20:0] CP_DIAC_B_HI   = 21'h0006ED;
    localparam logic [20:0] CP_ALEF_MADDA  = 21'h000622;
    localparam logic [20:0] CP_ALEF_HAMZA  = 21'h000623;
    localparam logic [20:0] CP_ALEF_BELOW  = 21'h000625;
    localparam logic [20:0] CP_ALEF_WASLA  = 21'h000671;
    localparam logic [20:0] CP_ALEF        = 21'h000627;
    localparam logic [20:0] CP_ALEF_MAKSRA = 21'h000649;
    localparam logic [20:0] CP_YEH         = 21'h00064A;
    localparam logic [20:0] CP_TEH_MARBUTA = 21'h000629;
    localparam logic [20:0] CP_HEH         = 21'h000647;

    typedef struct packed {
        logic [20:0] acc;
        logic [1:0]  pend;
        logic        in_tok;
        logic [15:0] wr_off;
        logic [15:0] tok_start;
        logic [15:0] tok_done;
        logic        failed;
    } t_state;

    // Every word that one input byte causes: written bytes, then an optional
    // token end, then an optional done word; an error word stands alone.
    typedef struct packed {
        logic [2:0]       cnt;
        logic [2:0]       nb;
        logic [3:0][7:0]  bytes;
        logic [15:0]      boff;
        logic             tend;
        logic [15:0]      tnum;
        logic [15:0]      toff;
        logic [15:0]      tlen;
        logic [15:0]      dcount;
        logic             err;
        t_err             ecode;
    } t_batch;

endpackage

`default_nettype wire

// ----- hdl/uanorm_step.sv -----
// Per-byte decode, normalize and tokenize logic of the tokenizer (combinational).
// Takes the stream state and one byte, gives the next state and the word batch.
// Depends on uanorm_pkg.
`default_nettype none

module uanorm_step import uanorm_pkg::*; (
    input  wire t_state      i_state,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    input  wire logic [15:0] i_tok_lim,
    input  wire logic [15:0] i_ws_lim,
    output t_state           o_state,
    output t_batch           o_batch
);

    function automatic logic [20:0] normalize(input logic [20:0] cp);
        logic [20:0] r;
        r = cp;
        if ((cp >= CP_DIAC_A_LO && cp <= CP_DIAC_A_HI) ||
            (cp >= CP_DIAC_B_LO && cp <= CP_DIAC_B_HI)) begin
            r = '0;
        end else if (cp == CP_ALEF_MADDA || cp == CP_ALEF_HAMZA ||
                     cp == CP_ALEF_BELOW || cp == CP_ALEF_WASLA) begin
            r = CP_ALEF;
        end else if (cp == CP_ALEF_MAKSRA) begin
            r = CP_YEH;
        end else if (cp == CP_TEH_MARBUTA) begin
            r = CP_HEH;
        end
        return r;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        logic d;
        if (c <= 8'h20) begin
            d = 1'b1;
        end else begin
            case (c)
                ",", ".", ";", ":", "!", "?", "\"", "'", "(", ")", "[", "]",
                "{", "}", "-", "_", "/", "\\", "+", "=", "*", "&", "%", "$",
                "#", "@", "<", ">": d = 1'b1;
                default:             d = 1'b0;
            endcase
        end
        return d;
    endfunction

    always_comb begin
        t_state      m;
        t_batch      b;
        logic        err;
        t_err        ecode;
        logic        have_cp;
        logic [20:0] cp;
        logic [20:0] ncp;
        logic        delim;
        logic [2:0]  n;
        logic [3:0][7:0] enc;
        logic        close_now;
        logic [20:0] acc_new;

        m       = i_state;
        b       = '0;
        err     = 1'b0;
        ecode   = ERR_UTF8;
        have_cp = 1'b0;
        cp      = '0;
        delim   = 1'b0;
        n       = 3'd0;
        enc     = '0;
        acc_new = {i_state.acc[14:0], i_byte[5:0]};

        if (i_state.pend != 2'd0) begin
            if (i_byte[7:6] != 2'b10) begin
                err = 1'b1;
            end else begin
                m.acc  = acc_new;
                m.pend = i_state.pend - 2'd1;
                if (i_state.pend == 2'd1) begin
                    have_cp = 1'b1;
                    cp      = acc_new;
                end
            end
        end else if (i_byte[7] == 1'b0) begin
            have_cp = 1'b1;
            cp      = {13'd0, i_byte};
        end else if (i_byte[7:5] == 3'b110) begin
            m.acc  = {16'd0, i_byte[4:0]};
            m.pend = 2'd1;
        end else if (i_byte[7:4] == 4'b1110) begin
            m.acc  = {17'd0, i_byte[3:0]};
            m.pend = 2'd2;
        end else if (i_byte[7:3] == 5'b11110) begin
            m.acc  = {18'd0, i_byte[2:0]};
            m.pend = 2'd3;
        end else begin
            err = 1'b1;
        end

        ncp = normalize(cp);
        if (ncp < 21'h80) begin
            n   = 3'd1;
            enc[0] = ncp[7:0];
        end else if (ncp < 21'h800) begin
            n   = 3'd2;
            enc[0] = {3'b110, ncp[10:6]};
            enc[1] = {2'b10, ncp[5:0]};
        end else if (ncp < 21'h10000) begin
            n   = 3'd3;
            enc[0] = {4'b1110, ncp[15:12]};
            enc[1] = {2'b10, ncp[11:6]};
            enc[2] = {2'b10, ncp[5:0]};
        end else begin
            n   = 3'd4;
            enc[0] = {5'b11110, ncp[20:18]};
            enc[1] = {2'b10, ncp[17:12]};
            enc[2] = {2'b10, ncp[11:6]};
            enc[3] = {2'b10, ncp[5:0]};
        end

        if (!err && have_cp && ncp != 21'd0) begin
            if (ncp < 21'h80 && is_delim(ncp[7:0])) begin
                delim = 1'b1;
            end else if (!i_state.in_tok && i_state.tok_done >= i_tok_lim) begin
                err   = 1'b1;
                ecode = ERR_TOKENS;
            end else if (({1'b0, i_state.wr_off} + {14'd0, n}) > {1'b0, i_ws_lim}) begin
                err   = 1'b1;
                ecode = ERR_WORKSPACE;
            end else begin
                if (!i_state.in_tok) begin
                    m.tok_start = i_state.wr_off;
                end
                m.in_tok = 1'b1;
                m.wr_off = i_state.wr_off + {13'd0, n};
                b.nb     = n;
                b.bytes  = enc;
                b.boff   = i_state.wr_off;
            end
        end

        if (!err && i_last && m.pend != 2'd0) begin
            err   = 1'b1;
            ecode = ERR_UTF8;
        end

        close_now = !err && m.in_tok && (delim || i_last);

        if (i_state.failed) begin
            b       = '0;
            o_state = i_state;
            if (i_last) begin
                o_state = '0;
            end
        end else if (err) begin
            b        = '0;
            b.cnt    = 3'd1;
            b.err    = 1'b1;
            b.ecode  = ecode;
            o_state  = '0;
            o_state.failed = !i_last;
        end else begin
            b.tend   = close_now;
            b.tnum   = m.tok_done;
            b.toff   = m.tok_start;
            b.tlen   = m.wr_off - m.tok_start;
            b.dcount = m.tok_done + {15'd0, close_now};
            if (close_now) begin
                m.tok_done = m.tok_done + 16'd1;
                m.in_tok   = 1'b0;
            end
            b.cnt   = b.nb + {2'd0, close_now} + {2'd0, i_last};
            o_state = i_last ? t_state'('0) : m;
        end
        o_batch = b;
    end

endmodule

`default_nettype wire

// ----- hdl/utf8_arabic_normalizing_tokenizer.sv -----
// Streaming UTF-8 normalizer and word tokenizer with Arabic folding.
// Usage:
//   The input stream carries one raw UTF-8 byte per word in s_axis_tdata, with
//   s_axis_tlast on the last byte of the text. The output stream carries one
//   record per word: kind in m_axis_tuser, fields in m_axis_tdata, and
//   m_axis_tlast on the last record that one input byte causes. Normalized
//   bytes, token-end, done and error records come in stream order.
//   The limit registers are written through i_cfg_we/i_cfg_addr/i_cfg_wdata
//   by the user only while idle, unenforced by the block; both reset to 65535.
//   An accepted byte's first record is registered and valid in the next cycle.
//   A byte that causes several records holds the input until its last record
//   is taken, since the single record register delivers one record per cycle
//   when not stalled, and bytes of zero or one record flow at one byte per cycle.
//   When the receiver stalls, the record register holds its record and the
//   input is held off until the last record of the current byte is accepted.
//   Synchronous reset clears the decoder, token counters and the valid flag of the
//   record register and restores both limits.
// Depends on uanorm_pkg and uanorm_step.
`default_nettype none

module utf8_arabic_normalizing_tokenizer import uanorm_pkg::*; #(
    parameter int WORKSPACE_MAX = 65535,
    parameter int TOKEN_MAX     = 65535
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  wire logic        s_axis_tlast,   // final_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] out_byte, [23:8] byte_offset, [39:24] token_number,
    // [55:40] token_offset, [71:56] token_bytes, [73:72] error_code, [79:74] zero
    output logic [79:0]      m_axis_tdata,
    output logic [1:0]       m_axis_tuser,   // [1:0] record_kind
    output logic             m_axis_tlast    // run_end
);

    localparam logic [23:0] TokMaxC = 24'(TOKEN_MAX);
    localparam logic [23:0] WsMaxC  = 24'(WORKSPACE_MAX);

    logic [15:0] r_tok_lim;
    logic [15:0] r_ws_lim;
    t_state      r_state;
    t_state      n_state;
    t_batch      r_batch;
    t_batch      n_batch;
    logic        r_valid;
    logic [2:0]  r_idx;
    logic [15:0] eff_tok_lim;
    logic [15:0] eff_ws_lim;
    logic        last_rec;
    logic        out_take;
    logic        in_take;
    t_kind       kind;
    logic [7:0]  rec_byte;
    logic [15:0] rec_boff;

    assign eff_tok_lim = ({8'd0, r_tok_lim} < TokMaxC) ? r_tok_lim : TokMaxC[15:0];
    assign eff_ws_lim  = ({8'd0, r_ws_lim}  < WsMaxC)  ? r_ws_lim  : WsMaxC[15:0];

    uanorm_step u_step (
        .i_state   (r_state),
        .i_byte    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .i_tok_lim (eff_tok_lim),
        .i_ws_lim  (eff_ws_lim),
        .o_state   (n_state),
        .o_batch   (n_batch)
    );

    assign last_rec      = (r_idx == (r_batch.cnt - 3'd1));
    assign out_take      = r_valid && m_axis_tready;
    assign s_axis_tready = !r_valid || (m_axis_tready && last_rec);
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_lim <= 16'hFFFF;
            r_ws_lim  <= 16'hFFFF;
            r_state   <= '0;
            r_valid   <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_TOKEN_LIMIT:     r_tok_lim <= i_cfg_wdata;
                    REG_WORKSPACE_LIMIT: r_ws_lim  <= i_cfg_wdata;
                    default:             r_tok_lim <= r_tok_lim;
                endcase
            end
            if (in_take) begin
                r_state <= n_state;
                r_valid <= (n_batch.cnt != 3'd0);
                r_idx   <= '0;
            end else if (out_take) begin
                if (last_rec) begin
                    r_valid <= 1'b0;
                end else begin
                    r_idx <= r_idx + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_batch <= n_batch;
        end
    end

    always_comb begin
        if (r_batch.err) begin
            kind = KIND_ERROR;
        end else if (r_idx < r_batch.nb) begin
            kind = KIND_BYTE;
        end else if (r_batch.tend && r_idx == r_batch.nb) begin
            kind = KIND_TOKEN_END;
        end else begin
            kind = KIND_DONE;
        end
    end

    assign rec_byte = r_batch.bytes[r_idx[1:0]];
    assign rec_boff = r_batch.boff + {14'd0, r_idx[1:0]};

    always_comb begin
        m_axis_tdata = '0;
        case (kind)
            KIND_BYTE: begin
                m_axis_tdata[7:0]  = rec_byte;
                m_axis_tdata[23:8] = rec_boff;
            end
            KIND_TOKEN_END: begin
                m_axis_tdata[39:24] = r_batch.tnum;
                m_axis_tdata[55:40] = r_batch.toff;
                m_axis_tdata[71:56] = r_batch.tlen;
            end
            KIND_DONE: begin
                m_axis_tdata[39:24] = r_batch.dcount;
            end
            KIND_ERROR: begin
                m_axis_tdata[73:72] = r_batch.ecode;
            end
            default: begin
                m_axis_tdata = '0;
            end
        endcase
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = kind;
    assign m_axis_tlast  = last_rec;

endmodule

`default_nettype wire

// ----- hdl/uanorm_checker.sv -----
// Port-level checker for the tokenizer and the bind that attaches it.
// Depends on uanorm_pkg and the top level utf8_arabic_normalizing_tokenizer.
`default_nettype none

module uanorm_checker import uanorm_pkg::*; (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [79:0] m_axis_tdata,
    input wire logic [1:0]  m_axis_tuser,
    input wire logic        m_axis_tlast
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("record valid right after reset");

    a_error_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_ERROR) |-> m_axis_tlast)
        else $error("error record is not the last of its byte");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_DONE) |-> m_axis_tlast)
        else $error("done record is not the last of its byte");

    a_no_byte_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != KIND_BYTE) |->
        (m_axis_tdata[23:0] == 24'd0))
        else $error("non-byte record carries byte fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled record changed");

endmodule

bind utf8_arabic_normalizing_tokenizer uanorm_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for utf8_arabic_normalizing_tokenizer: directed UTF-8 rows, then random
// texts under several limits, each record checked against a local predictor or its typed row.
// Depends on uanorm_pkg and the tokenizer RTL.
`timescale 1ns / 1ps

module testbench;
    import uanorm_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int SQUEEZE_CYCLES = 400;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  ob;
        logic [15:0] boff;
        logic [15:0] tnum;
        logic [15:0] toff;
        logic [15:0] tlen;
        t_err        code;
        logic        last;
    } t_record;

    typedef struct packed {
        logic [7:0]  b;
        logic        fin;
        logic        typed;
        t_kind       kind;
        t_err        code;
        logic [15:0] count;
    } t_text_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_addr = REG_TOKEN_LIMIT;
    logic [15:0] i_cfg_wdata = 16'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    utf8_arabic_normalizing_tokenizer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Predictor state and limits.
    logic [15:0] lim_tokens = 16'hFFFF;
    logic [15:0] lim_space = 16'hFFFF;
    logic [20:0] dec_acc = '0;
    logic [1:0]  dec_pend = '0;
    logic        in_word = 1'b0;
    logic [15:0] wr_off = '0;
    logic [15:0] tok_start = '0;
    logic [15:0] tok_count = '0;
    logic        halted = 1'b0;

    t_record step_out[$];
    t_record pending_records[$];
    int      mismatches = 0;
    int      inputs_taken = 0;
    int      idle_cycles = 0;
    bit      sender_calm = 1'b0;
    bit      receiver_calm = 1'b0;
    bit      receiver_squeezed = 1'b0;

    logic [20:0] folded_points [10] = '{CP_ALEF_MADDA, CP_ALEF_HAMZA, CP_ALEF_BELOW,
        CP_ALEF_WASLA, CP_ALEF_MAKSRA, CP_TEH_MARBUTA, CP_DIAC_A_LO, CP_DIAC_A_HI,
        CP_DIAC_B_LO, CP_DIAC_B_HI};

    t_text_row directed_rows [25] = '{
        '{8'h80, 1'b1, 1'b1, KIND_ERROR, ERR_UTF8, 16'd0},
        '{8'h20, 1'b1, 1'b1, KIND_DONE,  ERR_UTF8, 16'd0},
        '{8'h41, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hD9, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'h8E, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hD8, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hA3, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hD9, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'h89, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hD8, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hA9, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hDB, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hAD, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hD9, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hB1, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'h00, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'h2C, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hC0, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'h81, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'h7F, 1'b1, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hC3, 1'b1, 1'b1, KIND_ERROR, ERR_UTF8, 16'd0},
        '{8'hC3, 1'b0, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'h41, 1'b0, 1'b1, KIND_ERROR, ERR_UTF8, 16'd0},
        '{8'hFF, 1'b1, 1'b0, KIND_BYTE,  ERR_UTF8, 16'd0},
        '{8'hF8, 1'b1, 1'b1, KIND_ERROR, ERR_UTF8, 16'd0}
    };

    function automatic void emit(t_kind k, logic [7:0] ob, logic [15:0] bo, logic [15:0] tn,
                                 logic [15:0] tofs, logic [15:0] tl, t_err code);
        t_record r;
        r = '{k, ob, bo, tn, tofs, tl, code, 1'b0};
        step_out.push_back(r);
    endfunction

    function automatic void clear_stream();
        dec_acc = '0;
        dec_pend = '0;
        in_word = 1'b0;
        wr_off = '0;
        tok_start = '0;
        tok_count = '0;
        halted = 1'b0;
    endfunction

    function automatic bit is_delim(logic [6:0] c);
        if (c <= 7'h20) return 1'b1;
        case (c)
            7'h21, 7'h22, 7'h23, 7'h24, 7'h25, 7'h26, 7'h27, 7'h28, 7'h29, 7'h2A, 7'h2B,
            7'h2C, 7'h2D, 7'h2E, 7'h2F, 7'h3A, 7'h3B, 7'h3C, 7'h3D, 7'h3E, 7'h3F, 7'h40,
            7'h5B, 7'h5C, 7'h5D, 7'h5F, 7'h7B, 7'h7D: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [20:0] fold_cp(logic [20:0] cp);
        if (cp >= CP_DIAC_A_LO && cp <= CP_DIAC_A_HI) return '0;
        if (cp >= CP_DIAC_B_LO && cp <= CP_DIAC_B_HI) return '0;
        if (cp == CP_ALEF_MADDA || cp == CP_ALEF_HAMZA || cp == CP_ALEF_BELOW ||
            cp == CP_ALEF_WASLA) return CP_ALEF;
        if (cp == CP_ALEF_MAKSRA) return CP_YEH;
        if (cp == CP_TEH_MARBUTA) return CP_HEH;
        return cp;
    endfunction

    function automatic void close_token();
        emit(KIND_TOKEN_END, 8'd0, 16'd0, tok_count, tok_start, wr_off - tok_start, ERR_UTF8);
        tok_count = tok_count + 16'd1;
        in_word = 1'b0;
    endfunction

    function automatic bit place_cp(input logic [20:0] raw, output t_err code);
        logic [20:0]      cp;
        logic [3:0][7:0]  enc;
        int               n;
        code = ERR_UTF8;
        cp = fold_cp(raw);
        enc = '0;
        if (cp == '0) return 1'b0;
        if (cp < 21'h80 && is_delim(cp[6:0])) begin
            if (in_word) close_token();
            return 1'b0;
        end
        if (!in_word) begin
            if (tok_count >= lim_tokens) begin
                code = ERR_TOKENS;
                return 1'b1;
            end
            tok_start = wr_off;
            in_word = 1'b1;
        end
        if (cp < 21'h80) begin
            n = 1;
            enc[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            n = 2;
            enc[0] = {3'b110, cp[10:6]};
            enc[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            n = 3;
            enc[0] = {4'b1110, cp[15:12]};
            enc[1] = {2'b10, cp[11:6]};
            enc[2] = {2'b10, cp[5:0]};
        end else begin
            n = 4;
            enc[0] = {5'b11110, cp[20:18]};
            enc[1] = {2'b10, cp[17:12]};
            enc[2] = {2'b10, cp[11:6]};
            enc[3] = {2'b10, cp[5:0]};
        end
        if (int'(wr_off) + n > int'(lim_space)) begin
            code = ERR_WORKSPACE;
            return 1'b1;
        end
        for (int k = 0; k < n; k++) begin
            emit(KIND_BYTE, enc[k], wr_off, 16'd0, 16'd0, 16'd0, ERR_UTF8);
            wr_off = wr_off + 16'd1;
        end
        return 1'b0;
    endfunction

    // Leaves in step_out every record that one input byte causes.
    function automatic void tokenize_byte(logic [7:0] c, logic fin);
        bit      bad;
        t_err    code;
        t_record tail;
        step_out = {};
        bad = 1'b0;
        code = ERR_UTF8;
        if (halted) begin
            if (fin) clear_stream();
            return;
        end
        if (dec_pend != 2'd0) begin
            if (c[7:6] != 2'b10) begin
                bad = 1'b1;
            end else begin
                dec_acc = {dec_acc[14:0], c[5:0]};
                dec_pend = dec_pend - 2'd1;
                if (dec_pend == 2'd0) bad = place_cp(dec_acc, code);
            end
        end else if (!c[7]) begin
            bad = place_cp({13'd0, c}, code);
        end else if (c[7:5] == 3'b110) begin
            dec_acc = {16'd0, c[4:0]};
            dec_pend = 2'd1;
        end else if (c[7:4] == 4'b1110) begin
            dec_acc = {17'd0, c[3:0]};
            dec_pend = 2'd2;
        end else if (c[7:3] == 5'b11110) begin
            dec_acc = {18'd0, c[2:0]};
            dec_pend = 2'd3;
        end else begin
            bad = 1'b1;
        end
        if (!bad && fin && dec_pend != 2'd0) begin
            bad = 1'b1;
            code = ERR_UTF8;
        end
        if (bad) begin
            step_out = {};
            emit(KIND_ERROR, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0, code);
            clear_stream();
            if (!fin) halted = 1'b1;
        end else if (fin) begin
            if (in_word) close_token();
            emit(KIND_DONE, 8'd0, 16'd0, tok_count, 16'd0, 16'd0, ERR_UTF8);
            clear_stream();
        end
        if (step_out.size() != 0) begin
            tail = step_out.pop_back();
            tail.last = 1'b1;
            step_out.push_back(tail);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin, input bit typed,
                             input t_record fixed);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 13);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        s_axis_tlast <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        inputs_taken++;
        tokenize_byte(b, fin);
        if (typed) begin
            pending_records.push_back(fixed);
        end else begin
            for (int k = 0; k < step_out.size(); k++) pending_records.push_back(step_out[k]);
        end
    endtask

    task automatic send_text(inout int sent);
        logic [7:0]  q[$];
        logic [20:0] cp;
        int          n_cp;
        int          r;
        int          len;
        sender_calm = ($urandom_range(0, 3) == 0);
        n_cp = $urandom_range(1, 16);
        for (int i = 0; i < n_cp; i++) begin
            r = $urandom_range(0, 99);
            len = 0;
            if (r < 25) begin
                cp = 21'($urandom_range(8'h21, 8'h7F));
            end else if (r < 35) begin
                cp = 21'($urandom_range(0, 8'h40));
            end else if (r < 65) begin
                cp = 21'($urandom_range(21'h600, 21'h6FF));
            end else if (r < 72) begin
                cp = folded_points[$urandom_range(0, 9)];
            end else if (r < 80) begin
                cp = 21'($urandom_range(21'h80, 21'h7FF));
            end else if (r < 87) begin
                cp = 21'($urandom_range(21'h800, 21'hFFFF));
            end else if (r < 92) begin
                cp = 21'($urandom_range(21'h10000, 21'h1FFFFF));
            end else if (r < 96) begin
                cp = 21'($urandom_range(0, 21'h7FF));
                len = (cp < 21'h80) ? $urandom_range(2, 4) : $urandom_range(3, 4);
            end else begin
                q.push_back(8'($urandom_range(0, 255)));
                continue;
            end
            if (len == 0) len = (cp < 21'h80) ? 1 : (cp < 21'h800) ? 2 : (cp < 21'h10000) ? 3 : 4;
            case (len)
                1: q.push_back(cp[7:0]);
                2: begin
                    q.push_back({3'b110, cp[10:6]});
                    q.push_back({2'b10, cp[5:0]});
                end
                3: begin
                    q.push_back({4'b1110, cp[15:12]});
                    q.push_back({2'b10, cp[11:6]});
                    q.push_back({2'b10, cp[5:0]});
                end
                default: begin
                    q.push_back({5'b11110, cp[20:18]});
                    q.push_back({2'b10, cp[17:12]});
                    q.push_back({2'b10, cp[11:6]});
                    q.push_back({2'b10, cp[5:0]});
                end
            endcase
        end
        // Now and then the text stops right after a lead byte or an invalid byte of 0xF8 and up.
        if ($urandom_range(0, 24) == 0) q.push_back(8'hC0 | 8'($urandom_range(0, 63)));
        for (int i = 0; i < q.size(); i++) send_byte(q[i], i == q.size() - 1, 1'b0, '0);
        sent += q.size();
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [15:0] tok, input logic [15:0] ws);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= REG_TOKEN_LIMIT;
        i_cfg_wdata <= tok;
        @(posedge i_clk);
        lim_tokens = tok;
        i_cfg_addr <= REG_WORKSPACE_LIMIT;
        i_cfg_wdata <= ws;
        @(posedge i_clk);
        lim_space = ws;
        i_cfg_we <= 1'b0;
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_record();
        t_record want;
        if (pending_records.size() == 0) begin
            mismatches++;
            $display("%0t: record expected none actual kind %0h data %0h", $time,
                     m_axis_tuser, m_axis_tdata);
        end else begin
            want = pending_records.pop_front();
            check_field("record_kind", 16'(want.kind), 16'(m_axis_tuser));
            check_field("out_byte", 16'(want.ob), 16'(m_axis_tdata[7:0]));
            check_field("byte_offset", want.boff, m_axis_tdata[23:8]);
            check_field("token_number", want.tnum, m_axis_tdata[39:24]);
            check_field("token_offset", want.toff, m_axis_tdata[55:40]);
            check_field("token_bytes", want.tlen, m_axis_tdata[71:56]);
            check_field("error_code", 16'(want.code), 16'(m_axis_tdata[73:72]));
            check_field("padding", 16'd0, 16'(m_axis_tdata[79:74]));
            check_field("run_end", 16'(want.last), 16'(m_axis_tlast));
        end
    endtask

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Receiver side; once it holds off long enough for the block to stall its input.
    initial begin : drain
        int gap;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!receiver_squeezed && inputs_taken >= 150) begin
                receiver_squeezed = 1'b1;
                gap = SQUEEZE_CYCLES;
            end else begin
                gap = receiver_calm ? 0 : $urandom_range(0, 13);
            end
            if ($urandom_range(0, 15) == 0) receiver_calm = !receiver_calm;
            if (gap != 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            check_record();
        end
    end

    initial begin : stimulus
        t_record     fixed;
        logic [15:0] tok_list [8];
        logic [15:0] ws_list [8];
        int          sent;
        tok_list = '{16'd0, 16'hFFFF, 16'd0, 16'd3, 16'hFFFF, 16'd2,
                     16'($urandom_range(1, 8)), 16'hFFFF};
        ws_list = '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd12, 16'd9,
                    16'($urandom_range(4, 60)), 16'hFFFF};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 25; i++) begin
            fixed = '{directed_rows[i].kind, 8'd0, 16'd0, directed_rows[i].count, 16'd0,
                      16'd0, directed_rows[i].code, 1'b1};
            send_byte(directed_rows[i].b, directed_rows[i].fin, directed_rows[i].typed, fixed);
        end
        for (int p = 0; p < 8; p++) begin
            set_limits(tok_list[p], ws_list[p]);
            sent = 0;
            while (sent < 40) send_text(sent);
        end
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/uanorm_pkg.sv
hdl/uanorm_step.sv
hdl/utf8_arabic_normalizing_tokenizer.sv
hdl/uanorm_checker.sv
tb/testbench.sv
